// ===== hw/rtl/mie_pkg.sv =====
package mie_pkg;

    localparam int unsigned DMEM_WORDS_DEF = 4096;
    localparam int unsigned REG_COUNT      = 32;

    localparam logic [31:0] TEXT_START_RST = 32'h0040_0000;
    localparam logic [31:0] DATA_BASE_RST  = 32'h1000_0000;
    localparam logic [31:0] EXIT_CODE      = 32'h0000_000A;

    localparam logic REG_TEXT_START = 1'b0;
    localparam logic REG_DATA_BASE  = 1'b1;

    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_REGIMM  = 6'h01;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_BLEZ    = 6'h06;
    localparam logic [5:0] OP_BGTZ    = 6'h07;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTI    = 6'h0A;
    localparam logic [5:0] OP_ANDI    = 6'h0C;
    localparam logic [5:0] OP_ORI     = 6'h0D;
    localparam logic [5:0] OP_XORI    = 6'h0E;
    localparam logic [5:0] OP_LUI     = 6'h0F;
    localparam logic [5:0] OP_LB      = 6'h20;
    localparam logic [5:0] OP_LH      = 6'h21;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_SB      = 6'h28;
    localparam logic [5:0] OP_SH      = 6'h29;
    localparam logic [5:0] OP_SW      = 6'h2B;

    localparam logic [5:0] FN_SLL     = 6'h00;
    localparam logic [5:0] FN_SRL     = 6'h02;
    localparam logic [5:0] FN_SRA     = 6'h03;
    localparam logic [5:0] FN_JR      = 6'h08;
    localparam logic [5:0] FN_JALR    = 6'h09;
    localparam logic [5:0] FN_SYSCALL = 6'h0C;
    localparam logic [5:0] FN_MFHI    = 6'h10;
    localparam logic [5:0] FN_MTHI    = 6'h11;
    localparam logic [5:0] FN_MFLO    = 6'h12;
    localparam logic [5:0] FN_MTLO    = 6'h13;
    localparam logic [5:0] FN_MULT    = 6'h18;
    localparam logic [5:0] FN_MULTU   = 6'h19;
    localparam logic [5:0] FN_DIV     = 6'h1A;
    localparam logic [5:0] FN_DIVU    = 6'h1B;
    localparam logic [5:0] FN_ADD     = 6'h20;
    localparam logic [5:0] FN_ADDU    = 6'h21;
    localparam logic [5:0] FN_SUB     = 6'h22;
    localparam logic [5:0] FN_SUBU    = 6'h23;
    localparam logic [5:0] FN_AND     = 6'h24;
    localparam logic [5:0] FN_OR      = 6'h25;
    localparam logic [5:0] FN_XOR     = 6'h26;
    localparam logic [5:0] FN_NOR     = 6'h27;
    localparam logic [5:0] FN_SLT     = 6'h2A;

    localparam logic [4:0] RT_BLTZ    = 5'd0;
    localparam logic [4:0] RT_BGEZ    = 5'd1;
    localparam logic [4:0] LINK_REG   = 5'd31;

    localparam logic [2:0] CLS_SIMPLE = 3'd0;
    localparam logic [2:0] CLS_MUL    = 3'd1;
    localparam logic [2:0] CLS_DIV    = 3'd2;
    localparam logic [2:0] CLS_LOAD   = 3'd3;
    localparam logic [2:0] CLS_STORE  = 3'd4;

    typedef struct packed {
        logic clr;
        logic accept;
        logic mul_start;
        logic div_start;
        logic div_step;
        logic mem_start;
        logic ld_req;
        logic ld_dat;
        logic st_byte;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic       clr_last;
        logic [2:0] cls;
        logic       div_last;
        logic       byte_last;
    } t_stat;

    typedef struct packed {
        logic [31:0] instr_pc;
        logic [31:0] next_pc;
        logic        reg_write;
        logic [4:0]  reg_index;
        logic [31:0] reg_value;
        logic [31:0] hi_value;
        logic [31:0] lo_value;
        logic        mem_write;
        logic        halted;
        logic        unimplemented;
    } t_result;

endpackage

// ===== hw/rtl/mie_ctrl.sv =====
module mie_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_instr_valid,
    input  logic          i_out_free,
    input  mie_pkg::t_stat i_stat,
    output mie_pkg::t_cmd  o_cmd,
    output logic          o_instr_ready
);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_LDRQ = 3'd4;
    localparam logic [2:0] S_LDDT = 3'd5;
    localparam logic [2:0] S_ST   = 3'd6;
    localparam logic [2:0] S_FIN  = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_instr_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (i_stat.cls)
                    mie_pkg::CLS_MUL: begin
                        o_cmd.mul_start = 1'b1;
                        n_state         = S_FIN;
                    end
                    mie_pkg::CLS_DIV: begin
                        o_cmd.div_start = 1'b1;
                        n_state         = S_DIV;
                    end
                    mie_pkg::CLS_LOAD: begin
                        o_cmd.mem_start = 1'b1;
                        n_state         = S_LDRQ;
                    end
                    mie_pkg::CLS_STORE: begin
                        o_cmd.mem_start = 1'b1;
                        n_state         = S_ST;
                    end
                    default: begin
                        if (i_out_free) begin
                            o_cmd.finish = 1'b1;
                            n_state      = S_IDLE;
                        end
                    end
                endcase
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_FIN;
                end
            end
            S_LDRQ: begin
                o_cmd.ld_req = 1'b1;
                n_state      = S_LDDT;
            end
            S_LDDT: begin
                o_cmd.ld_dat = 1'b1;
                n_state      = i_stat.byte_last ? S_FIN : S_LDRQ;
            end
            S_ST: begin
                o_cmd.st_byte = 1'b1;
                if (i_stat.byte_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_instr_ready = (r_state == S_IDLE);

endmodule

// ===== hw/rtl/mie_dpath.sv =====
module mie_dpath #(
    parameter int unsigned DMEM_WORDS = mie_pkg::DMEM_WORDS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mie_pkg::t_cmd    i_cmd,
    input  logic [31:0]      i_instruction,
    input  logic             i_pc_load,
    input  logic [31:0]      i_text_start,
    input  logic [31:0]      i_data_base,
    output mie_pkg::t_stat   o_stat,
    output mie_pkg::t_result o_res,
    output logic             o_running
);

    localparam int unsigned AW        = $clog2(DMEM_WORDS);
    localparam logic [31:0] WIN_BYTES = 32'(DMEM_WORDS * 4);

    logic [31:0] r_dmem [DMEM_WORDS];
    logic [31:0] r_gpr  [mie_pkg::REG_COUNT];
    logic [mie_pkg::REG_COUNT-1:0] r_gpr_vld;

    logic [AW-1:0] r_clr;
    logic [31:0]   r_ins;
    logic [31:0]   r_a;
    logic [31:0]   r_b;
    logic [31:0]   r_v0;
    logic [31:0]   r_pc;
    logic [31:0]   r_hi;
    logic [31:0]   r_lo;
    logic          r_run;
    logic [63:0]   r_prod;
    logic [31:0]   r_corr;
    logic [31:0]   r_quo;
    logic [31:0]   r_rem;
    logic [31:0]   r_dvs;
    logic [4:0]    r_dcnt;
    logic [1:0]    r_bi;
    logic [31:0]   r_ldv;
    logic          r_mw;
    logic [31:0]   r_rdata;
    logic [1:0]    r_rd_lane;
    logic          r_rd_in;

    logic [5:0]  w_op;
    logic [4:0]  w_rs;
    logic [4:0]  w_rt;
    logic [4:0]  w_rd;
    logic [4:0]  w_sa;
    logic [5:0]  w_fn;
    logic [31:0] w_imm;
    logic [31:0] w_simm;
    logic        w_sgn;
    logic        w_na;
    logic        w_nb;
    logic [1:0]  w_nb_m1;
    logic [2:0]  w_cls;
    logic [31:0] w_ba;
    logic [31:0] w_off;
    logic        w_inwin;
    logic [AW-1:0] w_widx;
    logic [32:0] w_rem_sh;
    logic [32:0] w_diff;
    logic [31:0] w_npc4;
    logic [31:0] w_btgt;
    logic [31:0] w_jtgt;

    logic        c_wr;
    logic [4:0]  c_widx;
    logic [31:0] c_wval;
    logic [31:0] c_npc;
    logic [31:0] c_hi;
    logic [31:0] c_lo;
    logic        c_halt;
    logic        c_unimp;
    logic        c_wr_ok;

    assign w_op   = r_ins[31:26];
    assign w_rs   = r_ins[25:21];
    assign w_rt   = r_ins[20:16];
    assign w_rd   = r_ins[15:11];
    assign w_sa   = r_ins[10:6];
    assign w_fn   = r_ins[5:0];
    assign w_imm  = {16'h0000, r_ins[15:0]};
    assign w_simm = {{16{r_ins[15]}}, r_ins[15:0]};
    assign w_sgn  = (w_fn == mie_pkg::FN_DIV);
    assign w_na   = w_sgn & r_a[31];
    assign w_nb   = w_sgn & r_b[31];
    assign w_nb_m1 = (w_op[1:0] == 2'b11) ? 2'd3 : w_op[1:0];

    assign w_npc4 = r_pc + 32'd4;
    assign w_btgt = w_npc4 + {w_simm[29:0], 2'b00};
    assign w_jtgt = {w_npc4[31:28], r_ins[25:0], 2'b00};

    assign w_ba    = r_a + w_simm + {30'd0, r_bi};
    assign w_off   = w_ba - i_data_base;
    assign w_inwin = (w_off < WIN_BYTES);
    assign w_widx  = w_off[AW+1:2];

    assign w_rem_sh = {r_rem, r_quo[31]};
    assign w_diff   = w_rem_sh - {1'b0, r_dvs};

    always_comb begin
        w_cls = mie_pkg::CLS_SIMPLE;
        if (r_run) begin
            if (w_op == mie_pkg::OP_SPECIAL) begin
                if (w_fn == mie_pkg::FN_MULT || w_fn == mie_pkg::FN_MULTU) begin
                    w_cls = mie_pkg::CLS_MUL;
                end else if (w_fn == mie_pkg::FN_DIV || w_fn == mie_pkg::FN_DIVU) begin
                    w_cls = mie_pkg::CLS_DIV;
                end
            end else if (w_op == mie_pkg::OP_LB || w_op == mie_pkg::OP_LH
                         || w_op == mie_pkg::OP_LW) begin
                w_cls = mie_pkg::CLS_LOAD;
            end else if (w_op == mie_pkg::OP_SB || w_op == mie_pkg::OP_SH
                         || w_op == mie_pkg::OP_SW) begin
                w_cls = mie_pkg::CLS_STORE;
            end
        end
    end

    assign o_stat.clr_last  = (r_clr == AW'(DMEM_WORDS - 1));
    assign o_stat.cls       = w_cls;
    assign o_stat.div_last  = (r_dcnt == 5'd31);
    assign o_stat.byte_last = (r_bi == w_nb_m1);

    always_comb begin
        c_wr    = 1'b1;
        c_widx  = w_rt;
        c_wval  = '0;
        c_npc   = w_npc4;
        c_hi    = r_hi;
        c_lo    = r_lo;
        c_halt  = 1'b0;
        c_unimp = 1'b0;
        if (w_op == mie_pkg::OP_SPECIAL) begin
            c_widx = w_rd;
            unique case (w_fn)
                mie_pkg::FN_SLL:  c_wval = r_b << w_sa;
                mie_pkg::FN_SRL:  c_wval = r_b >> w_sa;
                mie_pkg::FN_SRA:  c_wval = 32'($signed(r_b) >>> w_sa);
                mie_pkg::FN_JR: begin
                    c_wr  = 1'b0;
                    c_npc = r_a;
                end
                mie_pkg::FN_JALR: begin
                    c_wval = w_npc4;
                    c_npc  = r_a;
                end
                mie_pkg::FN_SYSCALL: begin
                    c_wr   = 1'b0;
                    c_halt = (r_v0 == mie_pkg::EXIT_CODE);
                end
                mie_pkg::FN_MFHI: c_wval = r_hi;
                mie_pkg::FN_MTHI: begin
                    c_wr = 1'b0;
                    c_hi = r_a;
                end
                mie_pkg::FN_MFLO: c_wval = r_lo;
                mie_pkg::FN_MTLO: begin
                    c_wr = 1'b0;
                    c_lo = r_a;
                end
                mie_pkg::FN_MULT: begin
                    c_wr = 1'b0;
                    c_hi = r_prod[63:32] - r_corr;
                    c_lo = r_prod[31:0];
                end
                mie_pkg::FN_MULTU: begin
                    c_wr = 1'b0;
                    c_hi = r_prod[63:32];
                    c_lo = r_prod[31:0];
                end
                mie_pkg::FN_DIV, mie_pkg::FN_DIVU: begin
                    c_wr = 1'b0;
                    if (r_b != 32'd0) begin
                        c_lo = (w_na != w_nb) ? (32'd0 - r_quo) : r_quo;
                        c_hi = w_na ? (32'd0 - r_rem) : r_rem;
                    end
                end
                mie_pkg::FN_ADD, mie_pkg::FN_ADDU: c_wval = r_a + r_b;
                mie_pkg::FN_SUB, mie_pkg::FN_SUBU: c_wval = r_a - r_b;
                mie_pkg::FN_AND: c_wval = r_a & r_b;
                mie_pkg::FN_OR:  c_wval = r_a | r_b;
                mie_pkg::FN_XOR: c_wval = r_a ^ r_b;
                mie_pkg::FN_NOR: c_wval = ~(r_a | r_b);
                mie_pkg::FN_SLT: c_wval = {31'd0, $signed(r_a) < $signed(r_b)};
                default: begin
                    c_wr    = 1'b0;
                    c_unimp = 1'b1;
                end
            endcase
        end else begin
            unique case (w_op)
                mie_pkg::OP_REGIMM: begin
                    c_wr = 1'b0;
                    if (w_rt == mie_pkg::RT_BLTZ) begin
                        if (r_a[31]) c_npc = w_btgt;
                    end else if (w_rt == mie_pkg::RT_BGEZ) begin
                        if (!r_a[31]) c_npc = w_btgt;
                    end else begin
                        c_unimp = 1'b1;
                    end
                end
                mie_pkg::OP_J: begin
                    c_wr  = 1'b0;
                    c_npc = w_jtgt;
                end
                mie_pkg::OP_JAL: begin
                    c_widx = mie_pkg::LINK_REG;
                    c_wval = w_npc4;
                    c_npc  = w_jtgt;
                end
                mie_pkg::OP_BEQ: begin
                    c_wr = 1'b0;
                    if (r_a == r_b) c_npc = w_btgt;
                end
                mie_pkg::OP_BNE: begin
                    c_wr = 1'b0;
                    if (r_a != r_b) c_npc = w_btgt;
                end
                mie_pkg::OP_BLEZ: begin
                    c_wr = 1'b0;
                    if (r_a[31] || r_a == 32'd0) c_npc = w_btgt;
                end
                mie_pkg::OP_BGTZ: begin
                    c_wr = 1'b0;
                    if (!r_a[31] && r_a != 32'd0) c_npc = w_btgt;
                end
                mie_pkg::OP_ADDI, mie_pkg::OP_ADDIU: c_wval = r_a + w_simm;
                mie_pkg::OP_SLTI: c_wval = {31'd0, $signed(r_a) < $signed(w_simm)};
                mie_pkg::OP_ANDI: c_wval = r_a & w_imm;
                mie_pkg::OP_ORI:  c_wval = r_a | w_imm;
                mie_pkg::OP_XORI: c_wval = r_a ^ w_imm;
                mie_pkg::OP_LUI:  c_wval = {r_ins[15:0], 16'h0000};
                mie_pkg::OP_LB:   c_wval = {{24{r_ldv[7]}}, r_ldv[7:0]};
                mie_pkg::OP_LH:   c_wval = {{16{r_ldv[15]}}, r_ldv[15:0]};
                mie_pkg::OP_LW:   c_wval = r_ldv;
                mie_pkg::OP_SB, mie_pkg::OP_SH, mie_pkg::OP_SW: c_wr = 1'b0;
                default: begin
                    c_wr    = 1'b0;
                    c_unimp = 1'b1;
                end
            endcase
        end
    end

    assign c_wr_ok = c_wr && (c_widx != 5'd0);

    always_comb begin
        if (r_run) begin
            o_res.instr_pc      = r_pc;
            o_res.next_pc       = c_npc;
            o_res.reg_write     = c_wr_ok;
            o_res.reg_index     = c_wr_ok ? c_widx : 5'd0;
            o_res.reg_value     = c_wr_ok ? c_wval : 32'd0;
            o_res.hi_value      = c_hi;
            o_res.lo_value      = c_lo;
            o_res.mem_write     = (w_cls == mie_pkg::CLS_STORE) && r_mw;
            o_res.halted        = c_halt;
            o_res.unimplemented = c_unimp;
        end else begin
            o_res.instr_pc      = r_pc;
            o_res.next_pc       = r_pc;
            o_res.reg_write     = 1'b0;
            o_res.reg_index     = 5'd0;
            o_res.reg_value     = 32'd0;
            o_res.hi_value      = r_hi;
            o_res.lo_value      = r_lo;
            o_res.mem_write     = 1'b0;
            o_res.halted        = 1'b1;
            o_res.unimplemented = 1'b0;
        end
    end

    assign o_running = r_run;

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            r_dmem[r_clr] <= '0;
        end else if (i_cmd.st_byte && w_inwin) begin
            r_dmem[w_widx][{w_off[1:0], 3'b000} +: 8] <= r_b[{r_bi, 3'b000} +: 8];
        end
        if (i_cmd.ld_req) begin
            r_rdata <= r_dmem[w_widx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_a <= r_gpr_vld[i_instruction[25:21]] ? r_gpr[i_instruction[25:21]] : 32'd0;
            r_b <= r_gpr_vld[i_instruction[20:16]] ? r_gpr[i_instruction[20:16]] : 32'd0;
        end
        if (i_cmd.finish && r_run && c_wr_ok) begin
            r_gpr[c_widx] <= c_wval;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_ins <= i_instruction;
        end
        if (i_cmd.mul_start) begin
            r_prod <= r_a * r_b;
            r_corr <= (r_a[31] ? r_b : 32'd0) + (r_b[31] ? r_a : 32'd0);
        end
        if (i_cmd.div_start) begin
            r_quo <= w_na ? (32'd0 - r_a) : r_a;
            r_dvs <= w_nb ? (32'd0 - r_b) : r_b;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            if (!w_diff[32]) begin
                r_rem <= w_diff[31:0];
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= w_rem_sh[31:0];
                r_quo <= {r_quo[30:0], 1'b0};
            end
        end
        if (i_cmd.ld_req) begin
            r_rd_lane <= w_off[1:0];
            r_rd_in   <= w_inwin;
        end
        if (i_cmd.mem_start) begin
            r_ldv <= '0;
        end else if (i_cmd.ld_dat) begin
            r_ldv[{r_bi, 3'b000} +: 8] <= r_rd_in ? r_rdata[{r_rd_lane, 3'b000} +: 8] : 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= '0;
            r_gpr_vld <= '0;
            r_v0      <= '0;
            r_pc      <= mie_pkg::TEXT_START_RST;
            r_hi      <= '0;
            r_lo      <= '0;
            r_run     <= 1'b1;
            r_dcnt    <= '0;
            r_bi      <= '0;
            r_mw      <= 1'b0;
        end else begin
            if (i_cmd.clr) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.div_start) begin
                r_dcnt <= '0;
            end else if (i_cmd.div_step) begin
                r_dcnt <= r_dcnt + 5'd1;
            end
            if (i_cmd.mem_start) begin
                r_bi <= '0;
                r_mw <= 1'b0;
            end else if (i_cmd.ld_dat || i_cmd.st_byte) begin
                r_bi <= r_bi + 2'd1;
                if (i_cmd.st_byte && w_inwin) begin
                    r_mw <= 1'b1;
                end
            end
            priority if (i_cmd.finish && r_run) begin
                r_pc  <= c_npc;
                r_hi  <= c_hi;
                r_lo  <= c_lo;
                r_run <= !c_halt;
                if (c_wr_ok) begin
                    r_gpr_vld[c_widx] <= 1'b1;
                    if (c_widx == 5'd2) begin
                        r_v0 <= c_wval;
                    end
                end
            end else if (i_pc_load) begin
                r_pc <= i_text_start;
            end else begin
                r_pc <= r_pc;
            end
        end
    end

endmodule

// ===== hw/rtl/mips_integer_instruction_executor.sv =====
// MIPS I integer executor: the block reports the fetch address on each result's next_pc
// and takes the instruction word found there; one instruction is in flight at a time.
// After reset a clearing pass zeroes the data memory word by word, during which no
// instruction transfer is taken (configuration writes still are). Most instructions
// read the register file, then execute and commit; MULT/MULTU form a registered 32x32
// product, which MULT then corrects for signed operands; DIV/DIVU produce one quotient
// bit per cycle. The data memory port moves one byte at a time (a store writes one
// byte per cycle, a load requests then captures each byte), so unaligned and
// window-edge accesses are exact. A result waits in an output register; writing
// text_start also reloads the program counter unless an instruction commits in the same cycle.
module mips_integer_instruction_executor #(
    parameter int unsigned DMEM_WORDS = mie_pkg::DMEM_WORDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_instr_valid,
    output logic        o_instr_ready,
    input  logic [31:0] i_instruction,
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output logic [31:0] o_instr_pc,
    output logic [31:0] o_next_pc,
    output logic        o_reg_write,
    output logic [4:0]  o_reg_index,
    output logic [31:0] o_reg_value,
    output logic [31:0] o_hi_value,
    output logic [31:0] o_lo_value,
    output logic        o_mem_write,
    output logic        o_halted,
    output logic        o_unimplemented,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [31:0] r_text_start;
    logic [31:0] r_data_base;
    logic        r_ovld;
    mie_pkg::t_result r_out;

    mie_pkg::t_cmd    w_cmd;
    mie_pkg::t_stat   w_stat;
    mie_pkg::t_result w_res;
    logic             w_out_free;
    logic             w_cfg_wr;
    logic             w_running;

    assign pready     = 1'b1;
    assign w_cfg_wr   = psel && penable && pwrite && pready;
    assign prdata     = (paddr[2] == mie_pkg::REG_DATA_BASE) ? r_data_base : r_text_start;
    assign w_out_free = !r_ovld || i_res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_start <= mie_pkg::TEXT_START_RST;
            r_data_base  <= mie_pkg::DATA_BASE_RST;
        end else if (w_cfg_wr) begin
            if (paddr[2] == mie_pkg::REG_DATA_BASE) begin
                r_data_base <= pwdata;
            end else begin
                r_text_start <= pwdata;
            end
        end
    end

    mie_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_instr_valid (i_instr_valid),
        .i_out_free    (w_out_free),
        .i_stat        (w_stat),
        .o_cmd         (w_cmd),
        .o_instr_ready (o_instr_ready)
    );

    mie_dpath #(
        .DMEM_WORDS (DMEM_WORDS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_instruction (i_instruction),
        .i_pc_load     (w_cfg_wr && (paddr[2] == mie_pkg::REG_TEXT_START)),
        .i_text_start  (pwdata),
        .i_data_base   (r_data_base),
        .o_stat        (w_stat),
        .o_res         (w_res),
        .o_running     (w_running)
    );

    always_ff @(posedge i_clk) begin
        if (w_cmd.finish) begin
            r_out <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (w_cmd.finish) begin
            r_ovld <= 1'b1;
        end else if (i_res_ready) begin
            r_ovld <= 1'b0;
        end
    end

    assign o_res_valid     = r_ovld;
    assign o_instr_pc      = r_out.instr_pc;
    assign o_next_pc       = r_out.next_pc;
    assign o_reg_write     = r_out.reg_write;
    assign o_reg_index     = r_out.reg_index;
    assign o_reg_value     = r_out.reg_value;
    assign o_hi_value      = r_out.hi_value;
    assign o_lo_value      = r_out.lo_value;
    assign o_mem_write     = r_out.mem_write;
    assign o_halted        = r_out.halted;
    assign o_unimplemented = r_out.unimplemented;

    a_halt_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_running |=> !w_running)
        else $error("execution resumed after halt");

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.clr |-> !o_instr_ready)
        else $error("instruction offered during memory clear");

    a_finish_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.finish |-> w_out_free)
        else $error("result overwrote a pending transfer");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.accept |=> !o_instr_ready)
        else $error("second instruction taken while one is in flight");

endmodule
